### rtl/qte_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle unit.
// Holds the arctangent table used by the CORDIC stages.
// No dependencies; every other file refers to this package by scoped names.
package qte_pkg;

    // Field widths of the input and output transactions.
    localparam int COMP_W  = 16;
    localparam int PITCH_W = 15;
    localparam int ANGLE_W = 16;

    // Number formats.
    localparam int COMPONENT_FRAC_BITS = 14;
    localparam int ANGLE_FRAC_BITS     = 13;
    localparam int CORDIC_STEPS        = 16;
    localparam int ZFRAC               = 30;

    // Products, sums and magnitudes of the trigonometric arguments.
    localparam int PROD_W = 2 * COMP_W;
    localparam int TERM_W = PROD_W + 2;
    localparam int MAG_W  = TERM_W - 1;
    localparam int Z_W    = TERM_W;

    // Leading-zero normalizer: shifts of 32, 16, 8, 4, 2 and 1.
    localparam int NORM_STAGES = 6;

    // Square root path of the pitch term.
    localparam int SQ_W          = 2 * ZFRAC;
    localparam int RAD_W         = SQ_W + 1;
    localparam int ROOT_W        = ZFRAC + 1;
    localparam int ISQ_W         = RAD_W + 1;
    localparam int ISQRT_STAGES  = (RAD_W + 1) / 2;
    localparam int SIN_SHIFT     = ZFRAC - 2 * COMPONENT_FRAC_BITS;

    // Angle constants in Q.30.
    localparam logic [31:0] PI_Z     = 32'd3373259426;
    localparam logic [31:0] HALFPI_Z = 32'd1686629713;
    localparam int ANGLE_SHIFT = ZFRAC - ANGLE_FRAC_BITS;
    localparam logic [32:0] ROUND_HALF = 33'd1 << (ANGLE_SHIFT - 1);
    localparam logic [32:0] PITCH_LIMIT_WIDE = ({1'b0, HALFPI_Z} + ROUND_HALF) >> ANGLE_SHIFT;
    localparam logic signed [PITCH_W-1:0] PITCH_LIMIT = signed'(PITCH_W'(PITCH_LIMIT_WIDE));
    localparam logic signed [ANGLE_W-1:0] ANGLE_PI = 16'sd25736;

    // Value 1.0 of a doubled product term.
    localparam logic signed [TERM_W-1:0] ONE_TERM =
        TERM_W'(1) << (2 * COMPONENT_FRAC_BITS);
    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << (2 * COMPONENT_FRAC_BITS);

    // Pipeline layout, counted in register stages from the input.
    localparam int ATAN_STAGES  = 1 + NORM_STAGES + CORDIC_STEPS + 2;
    localparam int PITCH_START  = 5 + ISQRT_STAGES;
    localparam int PIPE_DEPTH   = PITCH_START + ATAN_STAGES;
    localparam int SIN_DLY      = PITCH_START - 3;
    localparam int FLAG_DLY     = PIPE_DEPTH - 3;
    localparam int YR_DLY       = PIPE_DEPTH - (2 + ATAN_STAGES);

    typedef struct packed {
        logic signed [PITCH_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
        logic signed [ANGLE_W-1:0] roll_angle;
        logic                      pitch_clamped;
    } euler_t;

    // Arctangent of 2^-i in Q.30.
    function automatic logic [31:0] atan_tab(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:  val = 32'h3243F6A8;
            5'd1:  val = 32'h1DAC6705;
            5'd2:  val = 32'h0FADBAFC;
            5'd3:  val = 32'h07F56EA6;
            5'd4:  val = 32'h03FEAB76;
            5'd5:  val = 32'h01FFD55B;
            5'd6:  val = 32'h00FFFAAA;
            5'd7:  val = 32'h007FFF55;
            5'd8:  val = 32'h003FFFEA;
            5'd9:  val = 32'h001FFFFD;
            5'd10: val = 32'h000FFFFF;
            5'd11: val = 32'h0007FFFF;
            5'd12: val = 32'h0003FFFF;
            5'd13: val = 32'h0001FFFF;
            5'd14: val = 32'h0000FFFF;
            5'd15: val = 32'h00007FFF;
            5'd16: val = 32'h00003FFF;
            5'd17: val = 32'h00001FFF;
            5'd18: val = 32'h00000FFF;
            5'd19: val = 32'h000007FF;
            5'd20: val = 32'h000003FF;
            5'd21: val = 32'h000001FF;
            5'd22: val = 32'h000000FF;
            5'd23: val = 32'h0000007F;
            5'd24: val = 32'h0000003F;
            5'd25: val = 32'h0000001F;
            5'd26: val = 32'h0000000F;
            5'd27: val = 32'h00000008;
            5'd28: val = 32'h00000004;
            5'd29: val = 32'h00000002;
            5'd30: val = 32'h00000001;
            default: val = 32'h00000000;
        endcase
        return val;
    endfunction

endpackage

### rtl/qte_if.sv
// Valid/ready channel interfaces for quaternion input and Euler angle output.
// Depends on qte_pkg for the field widths.
interface qte_quat_if;
    logic                                valid;
    logic                                ready;
    logic signed [qte_pkg::COMP_W-1:0]   quat_x;
    logic signed [qte_pkg::COMP_W-1:0]   quat_y;
    logic signed [qte_pkg::COMP_W-1:0]   quat_z;
    logic signed [qte_pkg::COMP_W-1:0]   quat_w;

    modport source (output valid, output quat_x, output quat_y, output quat_z,
                    output quat_w, input ready);
    modport sink (input valid, input quat_x, input quat_y, input quat_z,
                  input quat_w, output ready);
endinterface

interface qte_euler_if;
    logic                                valid;
    logic                                ready;
    logic signed [qte_pkg::PITCH_W-1:0]  pitch_angle;
    logic signed [qte_pkg::ANGLE_W-1:0]  yaw_angle;
    logic signed [qte_pkg::ANGLE_W-1:0]  roll_angle;
    logic                                pitch_clamped;

    modport source (output valid, output pitch_angle, output yaw_angle,
                    output roll_angle, output pitch_clamped, input ready);
    modport sink (input valid, input pitch_angle, input yaw_angle,
                  input roll_angle, input pitch_clamped, output ready);
endinterface

### rtl/quaternion_to_euler_angles_unit.sv
// Quaternion to Euler angles: products, sine/cosine terms, square root and
// three pipelined arctangent units. Depends on qte_pkg, qte_if, qte_isqrt, qte_atan2.
// One transaction per cycle is sustained by the fully pipelined CORDIC and square
// root stages while the skid entry is free. Input ready drops only while the skid
// entry holds a result. rst_n clears all valid bits; data registers are not reset.
module quaternion_to_euler_angles_unit (
    input  logic               clk,
    input  logic               rst_n,
    qte_quat_if.sink           quat_in,
    qte_euler_if.source        euler_out
);

    localparam int TW = qte_pkg::TERM_W;
    localparam int PW = qte_pkg::PROD_W;
    localparam int DEPTH = qte_pkg::PIPE_DEPTH;

    logic en;
    logic [DEPTH:1] v_reg;

    // Stage 1: the nine component products.
    logic signed [PW-1:0] p_wy_reg, p_xz_reg, p_yy_reg, p_zz_reg;
    logic signed [PW-1:0] p_wz_reg, p_xy_reg, p_xx_reg, p_wx_reg, p_yz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wy_reg <= PW'(quat_in.quat_w) * PW'(quat_in.quat_y);
            p_xz_reg <= PW'(quat_in.quat_x) * PW'(quat_in.quat_z);
            p_yy_reg <= PW'(quat_in.quat_y) * PW'(quat_in.quat_y);
            p_zz_reg <= PW'(quat_in.quat_z) * PW'(quat_in.quat_z);
            p_wz_reg <= PW'(quat_in.quat_w) * PW'(quat_in.quat_z);
            p_xy_reg <= PW'(quat_in.quat_x) * PW'(quat_in.quat_y);
            p_xx_reg <= PW'(quat_in.quat_x) * PW'(quat_in.quat_x);
            p_wx_reg <= PW'(quat_in.quat_w) * PW'(quat_in.quat_x);
            p_yz_reg <= PW'(quat_in.quat_y) * PW'(quat_in.quat_z);
        end
    end

    // Stage 2: doubled sums that form the arctangent and sine arguments.
    logic signed [TW-1:0] yaw_num_reg, yaw_den_reg, roll_num_reg, roll_den_reg;
    logic signed [TW-1:0] sin_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yaw_num_reg  <= (TW'(p_wy_reg) + TW'(p_xz_reg)) <<< 1;
            yaw_den_reg  <= qte_pkg::ONE_TERM - ((TW'(p_yy_reg) + TW'(p_zz_reg)) <<< 1);
            roll_num_reg <= (TW'(p_wz_reg) + TW'(p_xy_reg)) <<< 1;
            roll_den_reg <= qte_pkg::ONE_TERM - ((TW'(p_xx_reg) + TW'(p_yy_reg)) <<< 1);
            sin_reg      <= (TW'(p_wx_reg) - TW'(p_yz_reg)) <<< 1;
        end
    end

    // Stage 3: sine magnitude in Q.30 and saturation check.
    logic [qte_pkg::MAG_W-1:0] sin_mag;
    logic [qte_pkg::ZFRAC-1:0] s30_reg;
    logic                      sneg_reg;
    logic                      clamp_reg;

    assign sin_mag = qte_pkg::MAG_W'(sin_reg[TW-1] ? -sin_reg : sin_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s30_reg   <= qte_pkg::ZFRAC'(sin_mag << qte_pkg::SIN_SHIFT);
            sneg_reg  <= sin_reg[TW-1];
            clamp_reg <= (sin_mag >= qte_pkg::ONE_MAG);
        end
    end

    // Stages 4 and 5: cosine squared as 1 - s^2 in Q.60.
    logic [qte_pkg::SQ_W-1:0]  sq_reg;
    logic [qte_pkg::RAD_W-1:0] rad_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg  <= qte_pkg::SQ_W'(s30_reg) * qte_pkg::SQ_W'(s30_reg);
            rad_reg <= (qte_pkg::RAD_W'(1) << qte_pkg::SQ_W) - qte_pkg::RAD_W'(sq_reg);
        end
    end

    logic [qte_pkg::ROOT_W-1:0] cos_root;

    qte_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (rad_reg),
        .root     (cos_root)
    );

    // Delay lines that keep side data aligned with the square root and the
    // arctangent units.
    logic [qte_pkg::ZFRAC:0]    sin_dly_reg  [0:qte_pkg::SIN_DLY-1];
    logic [1:0]                 flag_dly_reg [0:qte_pkg::FLAG_DLY-1];
    logic signed [qte_pkg::ANGLE_W-1:0] yaw_dly_reg  [0:qte_pkg::YR_DLY-1];
    logic signed [qte_pkg::ANGLE_W-1:0] roll_dly_reg [0:qte_pkg::YR_DLY-1];
    logic signed [qte_pkg::ANGLE_W-1:0] yaw_ang, roll_ang, pitch_ang;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_dly_reg[0]  <= {sneg_reg, s30_reg};
            flag_dly_reg[0] <= {sneg_reg, clamp_reg};
            yaw_dly_reg[0]  <= yaw_ang;
            roll_dly_reg[0] <= roll_ang;
            for (int k = 1; k < qte_pkg::SIN_DLY; k++)
                sin_dly_reg[k] <= sin_dly_reg[k-1];
            for (int k = 1; k < qte_pkg::FLAG_DLY; k++)
                flag_dly_reg[k] <= flag_dly_reg[k-1];
            for (int k = 1; k < qte_pkg::YR_DLY; k++)
            begin
                yaw_dly_reg[k]  <= yaw_dly_reg[k-1];
                roll_dly_reg[k] <= roll_dly_reg[k-1];
            end
        end
    end

    qte_atan2 u_yaw (
        .clk   (clk),
        .en    (en),
        .num   (yaw_num_reg),
        .den   (yaw_den_reg),
        .angle (yaw_ang)
    );

    qte_atan2 u_roll (
        .clk   (clk),
        .en    (en),
        .num   (roll_num_reg),
        .den   (roll_den_reg),
        .angle (roll_ang)
    );

    // Pitch is the arctangent of the sine over the recovered cosine.
    logic [qte_pkg::ZFRAC:0]  sin_last;
    logic signed [TW-1:0]     pitch_num;
    logic signed [TW-1:0]     pitch_den;

    assign sin_last  = sin_dly_reg[qte_pkg::SIN_DLY-1];
    assign pitch_num = sin_last[qte_pkg::ZFRAC]
                       ? -signed'(TW'(sin_last[qte_pkg::ZFRAC-1:0]))
                       : signed'(TW'(sin_last[qte_pkg::ZFRAC-1:0]));
    assign pitch_den = signed'(TW'(cos_root));

    qte_atan2 u_pitch (
        .clk   (clk),
        .en    (en),
        .num   (pitch_num),
        .den   (pitch_den),
        .angle (pitch_ang)
    );

    // Final result assembled from the last pipeline stage.
    logic [1:0]        flag_last;
    qte_pkg::euler_t   res;

    assign flag_last = flag_dly_reg[qte_pkg::FLAG_DLY-1];

    always_comb
    begin
        res.yaw_angle     = yaw_dly_reg[qte_pkg::YR_DLY-1];
        res.roll_angle    = roll_dly_reg[qte_pkg::YR_DLY-1];
        res.pitch_clamped = flag_last[0];
        if (flag_last[0])
            res.pitch_angle = flag_last[1] ? -qte_pkg::PITCH_LIMIT : qte_pkg::PITCH_LIMIT;
        else
            res.pitch_angle = signed'(pitch_ang[qte_pkg::PITCH_W-1:0]);
    end

    // Output register plus skid entry; the pipeline runs while the skid is free.
    logic            o_v_reg, s_v_reg;
    qte_pkg::euler_t o_data_reg, s_data_reg;
    logic            take;
    logic            push;

    assign en   = !s_v_reg;
    assign take = o_v_reg && euler_out.ready;
    assign push = en && v_reg[DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            o_v_reg <= 1'b0;
            s_v_reg <= 1'b0;
        end
        else
        begin
            if (en)
                v_reg <= {v_reg[DEPTH-1:1], quat_in.valid};
            if (s_v_reg)
            begin
                if (take)
                    s_v_reg <= 1'b0;
            end
            else if (push)
            begin
                if (o_v_reg && !take)
                    s_v_reg <= 1'b1;
                else
                    o_v_reg <= 1'b1;
            end
            else if (take)
            begin
                o_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_v_reg)
        begin
            if (take)
                o_data_reg <= s_data_reg;
        end
        else if (push)
        begin
            if (o_v_reg && !take)
                s_data_reg <= res;
            else
                o_data_reg <= res;
        end
    end

    assign quat_in.ready           = en;
    assign euler_out.valid         = o_v_reg;
    assign euler_out.pitch_angle   = o_data_reg.pitch_angle;
    assign euler_out.yaw_angle     = o_data_reg.yaw_angle;
    assign euler_out.roll_angle    = o_data_reg.roll_angle;
    assign euler_out.pitch_clamped = o_data_reg.pitch_clamped;

    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_v_reg |-> o_v_reg)
        else $error("skid entry valid while output register empty");

    // A stalled pipeline keeps its valid bits.
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg))
        else $error("pipeline valid bits moved during a stall");

    // A saturated pitch is exactly plus or minus half pi.
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (euler_out.valid && euler_out.pitch_clamped) |->
        (euler_out.pitch_angle == qte_pkg::PITCH_LIMIT ||
         euler_out.pitch_angle == -qte_pkg::PITCH_LIMIT))
        else $error("clamped pitch is not half pi");

    // Yaw stays within plus or minus pi.
    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler_out.valid |->
        (euler_out.yaw_angle <= qte_pkg::ANGLE_PI &&
         euler_out.yaw_angle >= -qte_pkg::ANGLE_PI))
        else $error("yaw out of range");

endmodule

### rtl/qte_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on qte_pkg for widths and the stage count.
module qte_isqrt (
    input  logic                              clk,
    input  logic                              en,
    input  logic [qte_pkg::RAD_W-1:0]         radicand,
    output logic [qte_pkg::ROOT_W-1:0]        root
);

    localparam int N = qte_pkg::ISQRT_STAGES;

    logic [qte_pkg::RAD_W-1:0] rem_reg  [0:N-1];
    logic [qte_pkg::ISQ_W-1:0] part_reg [0:N-1];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_step
            localparam int BITPOS = qte_pkg::RAD_W - 1 - 2 * k;
            logic [qte_pkg::RAD_W-1:0] rem_src;
            logic [qte_pkg::ISQ_W-1:0] part_src;
            logic [qte_pkg::ISQ_W-1:0] trial;
            logic [qte_pkg::ISQ_W-1:0] bit_val;

            if (k == 0)
            begin : g_first
                assign rem_src  = radicand;
                assign part_src = '0;
            end
            else
            begin : g_next
                assign rem_src  = rem_reg[k-1];
                assign part_src = part_reg[k-1];
            end

            // Trial subtraction of the current root estimate plus this bit.
            assign bit_val = qte_pkg::ISQ_W'(1) << BITPOS;
            assign trial   = part_src + bit_val;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if ({1'b0, rem_src} >= trial)
                    begin
                        rem_reg[k]  <= qte_pkg::RAD_W'({1'b0, rem_src} - trial);
                        part_reg[k] <= (part_src >> 1) + bit_val;
                    end
                    else
                    begin
                        rem_reg[k]  <= rem_src;
                        part_reg[k] <= part_src >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = qte_pkg::ROOT_W'(part_reg[N-1]);

endmodule

### rtl/qte_atan2.sv
// Pipelined four-quadrant arctangent: magnitude, normalizer, vectoring CORDIC
// and quadrant/rounding stages. Depends on qte_pkg for widths and the table.
module qte_atan2 (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [qte_pkg::TERM_W-1:0]    num,
    input  logic signed [qte_pkg::TERM_W-1:0]    den,
    output logic signed [qte_pkg::ANGLE_W-1:0]   angle
);

    localparam int NS = qte_pkg::NORM_STAGES;
    localparam int CS = qte_pkg::CORDIC_STEPS;
    localparam int MW = qte_pkg::MAG_W;
    localparam int TW = qte_pkg::TERM_W;

    typedef enum logic [1:0] {
        CASE_CORDIC,
        CASE_ORIGIN,
        CASE_ZERO_NUM,
        CASE_ZERO_DEN
    } case_t;

    typedef struct packed {
        logic  den_neg;
        logic  num_neg;
        case_t kind;
    } side_t;

    logic [MW-1:0]           ax_reg [0:NS];
    logic [MW-1:0]           ay_reg [0:NS];
    side_t                   side_reg [0:NS+CS];
    logic signed [TW-1:0]    cx_reg [0:CS-1];
    logic signed [TW-1:0]    cy_reg [0:CS-1];
    logic signed [qte_pkg::Z_W-1:0] z_reg [0:CS-1];

    logic [MW-1:0]           ax_next;
    logic [MW-1:0]           ay_next;
    side_t                   side_next;

    // Magnitudes and the special cases of the argument pair.
    always_comb
    begin
        ax_next = MW'(den[TW-1] ? -den : den);
        ay_next = MW'(num[TW-1] ? -num : num);
        side_next.den_neg = den[TW-1];
        side_next.num_neg = num[TW-1];
        if (ax_next == '0 && ay_next == '0)
            side_next.kind = CASE_ORIGIN;
        else if (ay_next == '0)
            side_next.kind = CASE_ZERO_NUM;
        else if (ax_next == '0)
            side_next.kind = CASE_ZERO_DEN;
        else
            side_next.kind = CASE_CORDIC;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg[0]   <= ax_next;
            ay_reg[0]   <= ay_next;
            side_reg[0] <= side_next;
            for (int k = 1; k <= NS + CS; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    genvar j, i;
    generate
        // Normalizer: shift both magnitudes left while the top bits are clear.
        for (j = 0; j < NS; j++) begin : g_norm
            localparam int SH = 1 << (NS - 1 - j);
            logic [MW-1:0] both;
            assign both = ax_reg[j] | ay_reg[j];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if ((both >> (MW - SH)) == '0)
                    begin
                        ax_reg[j+1] <= ax_reg[j] << SH;
                        ay_reg[j+1] <= ay_reg[j] << SH;
                    end
                    else
                    begin
                        ax_reg[j+1] <= ax_reg[j];
                        ay_reg[j+1] <= ay_reg[j];
                    end
                end
            end
        end

        // Vectoring CORDIC, one micro-rotation per stage.
        for (i = 0; i < CS; i++) begin : g_cordic
            logic signed [TW-1:0]          cx_src;
            logic signed [TW-1:0]          cy_src;
            logic signed [qte_pkg::Z_W-1:0] z_src;
            logic signed [qte_pkg::Z_W-1:0] step_ang;

            if (i == 0)
            begin : g_first
                assign cx_src = signed'(TW'(ax_reg[NS][MW-1 -: qte_pkg::ZFRAC]));
                assign cy_src = signed'(TW'(ay_reg[NS][MW-1 -: qte_pkg::ZFRAC]));
                assign z_src  = '0;
            end
            else
            begin : g_next
                assign cx_src = cx_reg[i-1];
                assign cy_src = cy_reg[i-1];
                assign z_src  = z_reg[i-1];
            end

            assign step_ang = signed'(qte_pkg::Z_W'(qte_pkg::atan_tab(5'(i))));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!cy_src[TW-1])
                    begin
                        cx_reg[i] <= cx_src + (cy_src >>> i);
                        cy_reg[i] <= cy_src - (cx_src >>> i);
                        z_reg[i]  <= z_src + step_ang;
                    end
                    else
                    begin
                        cx_reg[i] <= cx_src - (cy_src >>> i);
                        cy_reg[i] <= cy_src + (cx_src >>> i);
                        z_reg[i]  <= z_src - step_ang;
                    end
                end
            end
        end
    endgenerate

    // Clamp to the first quadrant, then restore the quadrant of the denominator.
    side_t                  post_side;
    logic signed [qte_pkg::Z_W-1:0] z_fin;
    logic [31:0]            quad_t;
    logic [31:0]            t_next;
    logic [31:0]            t_reg;
    logic                   neg_reg;
    logic                   origin_reg;

    assign post_side = side_reg[NS+CS];
    assign z_fin     = z_reg[CS-1];

    always_comb
    begin
        case (post_side.kind)
            CASE_ORIGIN:   quad_t = '0;
            CASE_ZERO_NUM: quad_t = '0;
            CASE_ZERO_DEN: quad_t = qte_pkg::HALFPI_Z;
            default:
            begin
                if (z_fin[qte_pkg::Z_W-1])
                    quad_t = '0;
                else if (z_fin > signed'(qte_pkg::Z_W'(qte_pkg::HALFPI_Z)))
                    quad_t = qte_pkg::HALFPI_Z;
                else
                    quad_t = z_fin[31:0];
            end
        endcase
        t_next = post_side.den_neg ? (qte_pkg::PI_Z - quad_t) : quad_t;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg      <= t_next;
            neg_reg    <= post_side.num_neg;
            origin_reg <= (post_side.kind == CASE_ORIGIN);
        end
    end

    // Round half up to the output format and apply the sign of the numerator.
    logic [32:0]                    rounded;
    logic signed [qte_pkg::ANGLE_W-1:0] mag_ang;

    assign rounded = {1'b0, t_reg} + qte_pkg::ROUND_HALF;
    assign mag_ang = signed'(qte_pkg::ANGLE_W'(rounded >> qte_pkg::ANGLE_SHIFT));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (origin_reg)
                angle <= '0;
            else if (neg_reg)
                angle <= -mag_ang;
            else
                angle <= mag_ang;
        end
    end

endmodule

### dv/tb_quaternion_to_euler_angles_unit.sv
// Self-checking testbench for quaternion_to_euler_angles_unit.
// Depends on qte_pkg and the channel interfaces in qte_if.sv; computes the
// expected pitch, yaw and roll of every quaternion and checks each result.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles_unit;

    localparam longint ONE_PROD   = 64'sd1 <<< (2 * qte_pkg::COMPONENT_FRAC_BITS);
    localparam longint LATENCY    = 61;
    localparam int     MAX_REPORT = 10;

    logic clk;
    logic rst_n;

    qte_quat_if  quat_ch ();
    qte_euler_if euler_ch ();

    quaternion_to_euler_angles_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .quat_in   (quat_ch.sink),
        .euler_out (euler_ch.source)
    );

    qte_pkg::euler_t angle_queue[$];
    int     mismatch_count;
    int     sent_count;
    int     result_count;
    int     clamp_count;
    bit     idle_enable;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, well above the slowest correct run.
    initial
    begin
        #5ms;
        $display("tb_quaternion_to_euler_angles_unit failed");
        $finish;
    end

    // Magnitude of a signed value.
    function automatic longint unsigned mag64(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // Round a Q.30 angle magnitude to the output fraction.
    function automatic longint unsigned angle_round(input longint unsigned t);
        return (t + (64'd1 << (qte_pkg::ZFRAC - 1 - qte_pkg::ANGLE_FRAC_BITS)))
               >> (qte_pkg::ZFRAC - qte_pkg::ANGLE_FRAC_BITS);
    endfunction

    // Four-quadrant arctangent through a vectoring CORDIC in the first quadrant.
    function automatic longint cordic_atan2(input longint num, input longint den);
        longint unsigned an, ad, t, r;
        longint cx, cy, acc, nx;
        an = mag64(num);
        ad = mag64(den);
        if (an == 0 && ad == 0)
            return 0;
        if (an == 0)
            t = 0;
        else if (ad == 0)
            t = qte_pkg::HALFPI_Z;
        else
        begin
            while ((ad | an) >= (64'd1 << 30))
            begin
                ad = ad >> 1;
                an = an >> 1;
            end
            while ((ad | an) < (64'd1 << 29))
            begin
                ad = ad << 1;
                an = an << 1;
            end
            cx = ad;
            cy = an;
            acc = 0;
            for (int i = 0; i < qte_pkg::CORDIC_STEPS; i++)
            begin
                if (cy >= 0)
                begin
                    nx = cx + (cy >>> i);
                    cy = cy - (cx >>> i);
                    acc = acc + longint'(qte_pkg::atan_tab(5'(i)));
                end
                else
                begin
                    nx = cx - (cy >>> i);
                    cy = cy + (cx >>> i);
                    acc = acc - longint'(qte_pkg::atan_tab(5'(i)));
                end
                cx = nx;
            end
            if (acc < 0)
                t = 0;
            else if (acc > longint'(qte_pkg::HALFPI_Z))
                t = qte_pkg::HALFPI_Z;
            else
                t = acc;
        end
        if (den < 0)
            t = longint'(qte_pkg::PI_Z) - t;
        r = angle_round(t);
        return num < 0 ? -longint'(r) : longint'(r);
    endfunction

    // Floor of the integer square root.
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Expected Euler angles of one quaternion.
    function automatic qte_pkg::euler_t predict_euler(
        input logic signed [qte_pkg::COMP_W-1:0] qx,
        input logic signed [qte_pkg::COMP_W-1:0] qy,
        input logic signed [qte_pkg::COMP_W-1:0] qz,
        input logic signed [qte_pkg::COMP_W-1:0] qw);
        qte_pkg::euler_t e;
        longint x, y, z, w, s, pitch;
        longint unsigned as, s30, c;
        x = qx;
        y = qy;
        z = qz;
        w = qw;
        e.yaw_angle  = qte_pkg::ANGLE_W'(cordic_atan2(2 * (w * y + x * z),
                                                      ONE_PROD - 2 * (y * y + z * z)));
        e.roll_angle = qte_pkg::ANGLE_W'(cordic_atan2(2 * (w * z + x * y),
                                                      ONE_PROD - 2 * (x * x + y * y)));
        s = 2 * (w * x - y * z);
        as = mag64(s);
        if (as >= ONE_PROD)
        begin
            pitch = angle_round(qte_pkg::HALFPI_Z);
            if (s < 0)
                pitch = -pitch;
            e.pitch_clamped = 1'b1;
        end
        else
        begin
            s30 = as << (qte_pkg::ZFRAC - 2 * qte_pkg::COMPONENT_FRAC_BITS);
            c = floor_sqrt((64'd1 << 60) - s30 * s30);
            pitch = cordic_atan2(s < 0 ? -longint'(s30) : longint'(s30), c);
            e.pitch_clamped = 1'b0;
        end
        e.pitch_angle = qte_pkg::PITCH_W'(pitch);
        return e;
    endfunction

    // Drop valid for an idle burst of random length.
    task automatic idle_burst();
        quat_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
    endtask

    // Send one quaternion and record its expected angles.
    task automatic send_quat(input logic signed [qte_pkg::COMP_W-1:0] qx,
                             input logic signed [qte_pkg::COMP_W-1:0] qy,
                             input logic signed [qte_pkg::COMP_W-1:0] qz,
                             input logic signed [qte_pkg::COMP_W-1:0] qw);
        quat_ch.valid  <= 1'b1;
        quat_ch.quat_x <= qx;
        quat_ch.quat_y <= qy;
        quat_ch.quat_z <= qz;
        quat_ch.quat_w <= qw;
        @(posedge clk);
        while (!quat_ch.ready)
            @(posedge clk);
        angle_queue.push_back(predict_euler(qx, qy, qz, qw));
        sent_count++;
        if (idle_enable && $urandom_range(0, 3) == 0)
            idle_burst();
    endtask

    // Random component within the Q2.14 unit range, sometimes the full width.
    function automatic logic signed [qte_pkg::COMP_W-1:0] rand_comp();
        if ($urandom_range(0, 9) == 0)
            return qte_pkg::COMP_W'($urandom);
        return qte_pkg::COMP_W'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    // Extremes, zero arguments, signs and saturation of the pitch term.
    task automatic test_directed();
        send_quat(0, 0, 0, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, -16384);
        send_quat(11585, 0, 0, 11585);
        send_quat(-11585, 0, 0, 11585);
        send_quat(0, 11585, 11585, 0);
        send_quat(0, 11585, -11585, 0);
        send_quat(16384, 0, 0, 16384);
        send_quat(-16384, 0, 0, 16384);
        send_quat(-32768, -32768, -32768, -32768);
        send_quat(32767, 32767, 32767, 32767);
        send_quat(-32768, 32767, -32768, 32767);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(-8192, 8192, -8192, 8192);
        send_quat(0, 11585, 0, 11585);
        send_quat(0, 0, 11585, -11585);
        send_quat(1, -1, 1, -1);
        send_quat(16384, 16384, 0, 0);
        send_quat(-16384, -16384, -16384, -16384);
    endtask

    // Random quaternions, mostly near unit length, with some noise.
    task automatic test_random(input int count);
        logic signed [qte_pkg::COMP_W-1:0] v[4];
        real nrm;
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 4; k++)
                v[k] = rand_comp();
            if ($urandom_range(0, 3) != 0)
            begin
                nrm = $sqrt(real'(v[0]) ** 2 + real'(v[1]) ** 2 + real'(v[2]) ** 2
                            + real'(v[3]) ** 2);
                if (nrm > 0.0)
                    for (int k = 0; k < 4; k++)
                        v[k] = qte_pkg::COMP_W'($rtoi(real'(v[k]) * 16384.0 / nrm));
            end
            send_quat(v[0], v[1], v[2], v[3]);
        end
    endtask

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && euler_ch.valid && euler_ch.ready)
        begin
            result_count++;
            if (euler_ch.pitch_clamped)
                clamp_count++;
            if (angle_queue.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORT)
                    $display("unexpected result transaction at %0t", $realtime);
            end
            else
            begin
                qte_pkg::euler_t want;
                want = angle_queue.pop_front();
                if (euler_ch.pitch_angle !== want.pitch_angle
                    || euler_ch.yaw_angle !== want.yaw_angle
                    || euler_ch.roll_angle !== want.roll_angle
                    || euler_ch.pitch_clamped !== want.pitch_clamped)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORT)
                        $display("mismatch: pitch %0d/%0d yaw %0d/%0d roll %0d/%0d clamp %0b/%0b",
                                 euler_ch.pitch_angle, want.pitch_angle,
                                 euler_ch.yaw_angle, want.yaw_angle,
                                 euler_ch.roll_angle, want.roll_angle,
                                 euler_ch.pitch_clamped, want.pitch_clamped);
                end
            end
        end
    end

    // Output stalls in random bursts while idling is enabled.
    initial
    begin
        euler_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                euler_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            euler_ch.ready <= 1'b1;
        end
    end

    // Test sequence.
    initial
    begin
        int waited;
        rst_n = 1'b0;
        idle_enable = 1'b1;
        mismatch_count = 0;
        sent_count = 0;
        result_count = 0;
        clamp_count = 0;
        quat_ch.valid  <= 1'b0;
        quat_ch.quat_x <= '0;
        quat_ch.quat_y <= '0;
        quat_ch.quat_z <= '0;
        quat_ch.quat_w <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(550);
        idle_enable = 1'b0;
        test_random(200);
        quat_ch.valid <= 1'b0;

        waited = 0;
        while (angle_queue.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d quaternions, checked %0d results, %0d with saturated pitch.",
                 sent_count, result_count, clamp_count);
        if (mismatch_count == 0 && angle_queue.size() == 0)
            $display("tb_quaternion_to_euler_angles_unit passed");
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     angle_queue.size());
            $display("tb_quaternion_to_euler_angles_unit failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/qte_pkg.sv
rtl/qte_if.sv
rtl/qte_isqrt.sv
rtl/qte_atan2.sv
rtl/quaternion_to_euler_angles_unit.sv
dv/tb_quaternion_to_euler_angles_unit.sv
